/* rtl/agp_pkg.sv */
// Shared constants and types for the packed genotype allele statistics block.
`timescale 1ns / 1ps

package agp_pkg;

  localparam int unsigned MAX_SAMPLES = 1048576;
  localparam int unsigned CNT_W       = 21;   // sample counts and positions
  localparam int unsigned ALLELE_W    = 22;   // allele sums
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned Q_W         = FRAC_BITS + 1;  // Q1.16 quotient
  localparam int unsigned DIV_W       = 22;   // divider operand width
  localparam int unsigned STEP_W      = 5;    // holds Q_W
  localparam int unsigned LANES       = 32;
  localparam int unsigned WORD_W      = 2 * LANES;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  // Totals of one finished variant, passed from the front part to the back part.
  typedef struct packed {
    logic [ALLELE_W-1:0] alleles;
    logic [CNT_W-1:0]    called;
    logic [CNT_W-1:0]    n_eff;
  } variant_sums_t;

endpackage

/* rtl/agp_front.sv */
// Front part: masks lanes past the sample count, classifies genotypes, accumulates sums.
`timescale 1ns / 1ps

module agp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [agp_pkg::WORD_W-1:0]   geno_word_i,
  input  logic                         last_word_i,
  input  logic [agp_pkg::CNT_W-1:0]    n_eff_i,
  input  logic [agp_pkg::QCNT_W-1:0]   q_count_i,
  output logic                         q_push_o,
  output agp_pkg::variant_sums_t       q_entry_o
);
  import agp_pkg::*;

  logic                    accept;
  logic [CNT_W-1:0]        pos_q, pos_d;
  logic                    s1_valid_q, s1_last_q;
  logic [LANES-1:0]        s1_called_q, called_d;
  logic [WORD_W-1:0]       s1_abits_q, abits_d;
  logic [CNT_W-1:0]        s1_n_q;
  logic [ALLELE_W-1:0]     asum_q, asum_next;
  logic [CNT_W-1:0]        csum_q, csum_next;
  logic [CNT_W:0]          diff;
  logic                    pos_below;
  logic [CNT_W:0]          pos_inc;
  logic [QCNT_W:0]         room_need;
  logic [5:0]              called_pop;
  logic [6:0]              allele_pop;

  // Block new words while the queue could not take a variant still in flight.
  assign room_need = {1'b0, q_count_i} + {{QCNT_W{1'b0}}, (s1_valid_q & s1_last_q)};
  assign full      = (room_need >= (QCNT_W + 1)'(QDEPTH));
  assign accept    = push & ~full;

  // Lane i is inside the variant when pos + i < n.
  assign diff      = {1'b0, n_eff_i} - {1'b0, pos_q};
  assign pos_below = (n_eff_i > pos_q);

  always_comb begin
    logic [1:0] code;
    logic       lane_ok;
    called_d = '0;
    abits_d  = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_ok = pos_below && ((diff[CNT_W-1:5] != '0) || (diff[4:0] > 5'(i)));
      code    = lane_ok ? geno_word_i[2*i +: 2] : 2'b01;
      called_d[i]      = (code != 2'b01);
      abits_d[2*i +: 2] = (code != 2'b01) ? code : 2'b00;
    end
  end

  assign pos_inc = {1'b0, pos_q} + (CNT_W + 1)'(LANES);
  always_comb begin
    if (last_word_i) begin
      pos_d = '0;
    end else if (pos_inc > (CNT_W + 1)'(MAX_SAMPLES)) begin
      pos_d = CNT_W'(MAX_SAMPLES);
    end else begin
      pos_d = pos_inc[CNT_W-1:0];
    end
  end

  always_comb begin
    called_pop = '0;
    allele_pop = '0;
    for (int i = 0; i < LANES; i++) begin
      called_pop = called_pop + 6'(s1_called_q[i]);
    end
    for (int i = 0; i < WORD_W; i++) begin
      allele_pop = allele_pop + 7'(s1_abits_q[i]);
    end
  end

  assign asum_next = asum_q + ALLELE_W'(allele_pop);
  assign csum_next = csum_q + CNT_W'(called_pop);

  assign q_push_o          = s1_valid_q & s1_last_q;
  assign q_entry_o.alleles = asum_next;
  assign q_entry_o.called  = csum_next;
  assign q_entry_o.n_eff   = s1_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      asum_q     <= '0;
      csum_q     <= '0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        pos_q     <= pos_d;
        s1_last_q <= last_word_i;
      end
      if (s1_valid_q) begin
        if (s1_last_q) begin
          asum_q <= '0;
          csum_q <= '0;
        end else begin
          asum_q <= asum_next;
          csum_q <= csum_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_called_q <= called_d;
      s1_abits_q  <= abits_d;
      s1_n_q      <= n_eff_i;
    end
  end

endmodule

/* rtl/agp_fifo.sv */
// Short queue of finished variant totals between the front and back parts.
`timescale 1ns / 1ps

module agp_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  agp_pkg::variant_sums_t      entry_i,
  input  logic                        pop_i,
  output agp_pkg::variant_sums_t      head_o,
  output logic                        empty_o,
  output logic [agp_pkg::QCNT_W-1:0]  count_o
);
  import agp_pkg::*;

  variant_sums_t       mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_pop;

  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

/* rtl/agp_div.sv */
// Restoring divider producing a Q1.16 quotient one bit per cycle.
`timescale 1ns / 1ps

module agp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [agp_pkg::DIV_W-1:0]  dividend_i,
  input  logic [agp_pkg::DIV_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [agp_pkg::Q_W-1:0]    quotient_o
);
  import agp_pkg::*;

  // The dividend never exceeds the divisor, so the quotient fits Q_W bits.
  logic [DIV_W:0]    rem_q, trial;
  logic [DIV_W-1:0]  div_q;
  logic [Q_W-1:0]    quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              run_q, done_q;
  logic              take;

  assign trial = (cnt_q == STEP_W'(Q_W)) ? rem_q : {rem_q[DIV_W-1:0], 1'b0};
  assign take  = (trial >= {1'b0, div_q});

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= STEP_W'(Q_W);
    end else if (run_q) begin
      cnt_q <= cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, dividend_i};
      div_q <= divisor_i;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= take ? (trial - {1'b0, div_q}) : trial;
      quo_q <= {quo_q[Q_W-2:0], take};
    end
  end

endmodule

/* rtl/agp_back.sv */
// Back part: takes variant totals, runs both rate divisions and holds the result item.
`timescale 1ns / 1ps

module agp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  agp_pkg::variant_sums_t        head_i,
  input  logic                          q_empty_i,
  output logic                          q_pop_o,
  input  logic                          pop,
  output logic                          empty,
  output logic [agp_pkg::ALLELE_W-1:0]  allele_count_o,
  output logic [agp_pkg::CNT_W-1:0]     called_count_o,
  output logic [agp_pkg::Q_W-1:0]       allele_freq_o,
  output logic [agp_pkg::Q_W-1:0]       missing_rate_o,
  output logic                          no_calls_o
);
  import agp_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } back_state_e;

  back_state_e         state_q;
  logic                out_valid_q;
  logic                slot_free;
  logic                start;
  logic                finish;
  logic [CNT_W-1:0]    missing;
  logic [ALLELE_W-1:0] alleles_q;
  logic [CNT_W-1:0]    called_q;
  logic                freq_done, rate_done;
  logic [Q_W-1:0]      freq_quo, rate_quo;

  assign slot_free = ~out_valid_q | pop;
  assign empty     = ~out_valid_q;
  assign start     = (state_q == ST_IDLE) & ~q_empty_i;
  assign q_pop_o   = start;
  assign finish    = (state_q == ST_RUN) & freq_done & rate_done & slot_free;

  // A count change within a variant can leave more calls than samples.
  assign missing = (head_i.called <= head_i.n_eff) ? (head_i.n_eff - head_i.called) : '0;

  agp_div u_freq_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (head_i.alleles),
    .divisor_i  ({head_i.called, 1'b0}),
    .done_o     (freq_done),
    .quotient_o (freq_quo)
  );

  agp_div u_rate_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i ({1'b0, missing}),
    .divisor_i  ({1'b0, head_i.n_eff}),
    .done_o     (rate_done),
    .quotient_o (rate_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      out_valid_q    <= 1'b0;
      alleles_q      <= '0;
      called_q       <= '0;
      allele_count_o <= '0;
      called_count_o <= '0;
      allele_freq_o  <= '0;
      missing_rate_o <= '0;
      no_calls_o     <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (finish) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      if (start) begin
        alleles_q <= head_i.alleles;
        called_q  <= head_i.called;
      end
      if (finish) begin
        allele_count_o <= alleles_q;
        called_count_o <= called_q;
        allele_freq_o  <= (called_q == '0) ? '0 : freq_quo;
        missing_rate_o <= rate_quo;
        no_calls_o     <= (called_q == '0);
      end
    end
  end

endmodule

/* rtl/packed_genotype_allele_stats.sv */
// Top level of the packed genotype allele statistics block.
`timescale 1ns / 1ps

// Usage: genotype words enter on a queue-style port. An item (one 64-bit word of 32
// two-bit codes plus a last-word flag) is taken when push is high and full is low.
// The word with last_word_i set closes a variant and produces one result item:
// allele and called counts, allele frequency and missing rate in unsigned Q1.16.
// Results leave through a queue-style port: while empty is low the oldest result
// is on the outputs, and it is taken when pop is high.
// Throughput: one word per cycle while full is low. Each word is classified in one
// stage and its called samples and alleles are counted and summed in the next;
// lanes past the configured sample count read as missing.
// Path of a result after the edge that takes its last word: one summing stage that
// also writes the variant queue, the start of the two bit-serial dividers, their 17
// steps, and the output register. The dividers set the pace of results: the back
// part takes the next variant only once the last has left them. A four-entry queue
// holds finished variants meanwhile, so short variants back-to-back make full rise.
// If the receiver stalls, the result waits in the output register, the dividers
// hold their quotients and the queue fills; full then stops new words.
// Reset clears all sums, the sample position, the queue and the output, and sets
// sample_count to one. Write sample_count only between variants.
module packed_genotype_allele_stats (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sample_count_we_i,
  input  logic [agp_pkg::CNT_W-1:0]     sample_count_i,
  input  logic                          push,
  output logic                          full,
  input  logic [agp_pkg::WORD_W-1:0]    geno_word_i,
  input  logic                          last_word_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [agp_pkg::ALLELE_W-1:0]  allele_count_o,
  output logic [agp_pkg::CNT_W-1:0]     called_count_o,
  output logic [agp_pkg::Q_W-1:0]       allele_freq_o,
  output logic [agp_pkg::Q_W-1:0]       missing_rate_o,
  output logic                          no_calls_o
);
  import agp_pkg::*;

  logic [CNT_W-1:0]   sample_count_q;
  logic [CNT_W-1:0]   n_eff;
  logic               q_push, q_pop, q_empty;
  logic [QCNT_W-1:0]  q_count;
  variant_sums_t      q_entry, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= CNT_W'(1);
    end else if (sample_count_we_i) begin
      sample_count_q <= sample_count_i;
    end
  end

  // A count of zero behaves as one sample; counts above the maximum are clipped.
  always_comb begin
    if (sample_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (sample_count_q > CNT_W'(MAX_SAMPLES)) begin
      n_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      n_eff = sample_count_q;
    end
  end

  agp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .geno_word_i (geno_word_i),
    .last_word_i (last_word_i),
    .n_eff_i     (n_eff),
    .q_count_i   (q_count),
    .q_push_o    (q_push),
    .q_entry_o   (q_entry)
  );

  agp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  agp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (q_head),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .pop            (pop),
    .empty          (empty),
    .allele_count_o (allele_count_o),
    .called_count_o (called_count_o),
    .allele_freq_o  (allele_freq_o),
    .missing_rate_o (missing_rate_o),
    .no_calls_o     (no_calls_o)
  );

endmodule
